FILE: rtl/sampled_count_min_sketch_core_assert.svh
// Assertion macros shared by the sampled count-min sketch RTL.
`ifndef SAMPLED_COUNT_MIN_SKETCH_CORE_ASSERT_SVH
`define SAMPLED_COUNT_MIN_SKETCH_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define SCMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");
// The consequent must hold in the cycle after the antecedent.
`define SCMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SCMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/scms_pkg.sv
// Shared types, constants and hash functions of the sampled count-min sketch.
package scms_pkg;

  // Sketch geometry.
  localparam int ROWS       = 4;
  localparam int COLUMNS    = 1024;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int KEY_BYTES  = 13;
  localparam int KEY_W      = KEY_BYTES * 8;
  localparam int TUPLE_W    = 104;
  localparam int BYTE_CNT_W = $clog2(KEY_BYTES);

  // Work queue between the hash front and the counting back.
  localparam int WQ_DEPTH = 2;
  localparam int WQ_PTR_W = $clog2(WQ_DEPTH);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam logic [31:0] THRESHOLD_RESET = 32'd171798691;
  localparam logic REG_THRESHOLD = 1'b0;

  // Reflected CRC-32C polynomial and the per-row seeds.
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [3:0][31:0] ROW_SEED = {32'h00ec587f, 32'h00ec5861,
                                           32'h00ec5859, 32'h00ec5853};

  // Command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Request as it enters the block.
  typedef struct packed {
    logic        command;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol;
    logic [31:0] random_row0;
    logic [31:0] random_row1;
    logic [31:0] random_row2;
    logic [31:0] random_row3;
    logic [1:0]  read_row;
    logic [9:0]  read_column;
  } scms_in_t;

  // Result as it leaves the block.
  typedef struct packed {
    logic [31:0] counter_value;
    logic [3:0]  rows_updated;
  } scms_out_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic                       command;
    logic [ROWS-1:0]            mask;
    logic [ROWS-1:0][COL_W-1:0] cols;
    logic [1:0]                 read_row;
    logic [9:0]                 read_column;
  } scms_work_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_HASH,
    FE_PUSH
  } scms_front_e;

  typedef enum logic [1:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_READ,
    BE_WRITE
  } scms_back_e;

  // Key bytes in hash order, first byte in the top bits, zero padded.
  function automatic logic [KEY_W-1:0] scms_make_key(input scms_in_t item);
    logic [KEY_W-1:0] key;
    key = '0;
    key[KEY_W-1 -: TUPLE_W] = {item.source_address, item.destination_address,
                               item.source_port, item.destination_port,
                               item.protocol};
    return key;
  endfunction

  // One byte of the reflected CRC-32C.
  function automatic logic [31:0] scms_crc_byte(input logic [31:0] crc,
                                                input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/scms_hash_front.sv
// Front end: takes requests, decides the sampled rows and hashes the key.
`include "sampled_count_min_sketch_core_assert.svh"

module scms_hash_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  scms_pkg::scms_in_t  item_i,
  output logic                full_o,
  input  logic [31:0]         threshold_i,
  input  logic                hold_i,
  output logic                work_valid_o,
  input  logic                work_ready_i,
  output scms_pkg::scms_work_t work_o
);
  import scms_pkg::*;

  localparam logic [BYTE_CNT_W-1:0] BYTE_LAST = BYTE_CNT_W'(KEY_BYTES - 1);

  scms_front_e state_q, state_d;
  logic [BYTE_CNT_W-1:0]   cnt_q;
  logic [KEY_W-1:0]        key_q;
  logic [ROWS-1:0][31:0]   crc_q;
  logic                    cmd_q;
  logic [ROWS-1:0]         mask_q;
  logic [1:0]              rrow_q;
  logic [9:0]              rcol_q;
  logic                    accept;
  logic [3:0][31:0]        rnd;
  logic [ROWS-1:0]         mask_new;

  assign accept = push_i && !full_o;
  assign rnd    = {item_i.random_row3, item_i.random_row2,
                   item_i.random_row1, item_i.random_row0};

  // Sampling decision per row; a read touches no row.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      mask_new[r] = (item_i.command == CMD_UPDATE) && (rnd[r] < threshold_i);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (accept) begin
          state_d = (item_i.command == CMD_READ) ? FE_PUSH : FE_HASH;
        end
      end
      FE_HASH: begin
        if (cnt_q == BYTE_LAST) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (work_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full_o       = (state_q != FE_IDLE) || hold_i;
    work_valid_o = (state_q == FE_PUSH);
    work_o.command     = cmd_q;
    work_o.mask        = mask_q;
    work_o.read_row    = rrow_q;
    work_o.read_column = rcol_q;
    for (int r = 0; r < ROWS; r++) begin
      work_o.cols[r] = crc_q[r][COL_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == FE_HASH) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Key shift register and one CRC byte step per row and cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= scms_make_key(item_i);
      cmd_q  <= item_i.command;
      mask_q <= mask_new;
      rrow_q <= item_i.read_row;
      rcol_q <= item_i.read_column;
      for (int r = 0; r < ROWS; r++) begin
        crc_q[r] <= ROW_SEED[r];
      end
    end else if (state_q == FE_HASH) begin
      key_q <= key_q << 8;
      for (int r = 0; r < ROWS; r++) begin
        crc_q[r] <= scms_crc_byte(crc_q[r], key_q[KEY_W-1 -: 8]);
      end
    end
  end

  // The byte counter steps by one through every hashing cycle.
  `SCMS_ASSERT_NXT(a_hash_count, clk_i, rst_ni,
                   state_q == FE_HASH && cnt_q != BYTE_LAST,
                   cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: rtl/scms_work_fifo.sv
// Short queue of classified requests between the front and the back.
`include "sampled_count_min_sketch_core_assert.svh"

module scms_work_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  scms_pkg::scms_work_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output scms_pkg::scms_work_t data_o,
  output logic                 empty_o
);
  import scms_pkg::*;

  scms_work_t            entry_q [WQ_DEPTH];
  logic [WQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [WQ_PTR_W:0]     count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (WQ_PTR_W + 1)'(WQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill level never passes the depth.
  `SCMS_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1,
                   count_q <= (WQ_PTR_W + 1)'(WQ_DEPTH))

endmodule

FILE: rtl/scms_count_back.sv
// Back end: counter banks, clearing pass, read-modify-write and result register.
`include "sampled_count_min_sketch_core_assert.svh"

module scms_count_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 work_valid_i,
  input  scms_pkg::scms_work_t work_i,
  output logic                 work_pop_o,
  output logic                 clearing_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output scms_pkg::scms_out_t  result_o
);
  import scms_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  scms_back_e state_q, state_d;
  logic [COL_W-1:0]         clr_q;
  logic                     out_valid_q;
  scms_out_t                result_q;
  logic [ROWS-1:0]          we;
  logic [COL_W-1:0]         addr  [ROWS];
  logic [31:0]              wdata [ROWS];
  logic [31:0]              rdata [ROWS];
  logic [31:0]              read_sel;
  logic                     in_range;
  scms_out_t                result_new;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_CLEAR: begin
        if (clr_q == COL_LAST) begin
          state_d = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (work_valid_i && !out_valid_q) begin
          state_d = BE_READ;
        end
      end
      BE_READ:  state_d = BE_WRITE;
      BE_WRITE: state_d = BE_IDLE;
      default:  state_d = BE_IDLE;
    endcase
  end

  // Bank control: clear sweep, or increment of the sampled rows.
  always_comb begin
    clearing_o = (state_q == BE_CLEAR);
    work_pop_o = (state_q == BE_WRITE);
    for (int r = 0; r < ROWS; r++) begin
      if (state_q == BE_CLEAR) begin
        addr[r]  = clr_q;
        wdata[r] = '0;
        we[r]    = 1'b1;
      end else begin
        addr[r]  = (work_i.command == CMD_READ) ? COL_W'(work_i.read_column)
                                                 : work_i.cols[r];
        wdata[r] = rdata[r] + 32'd1;
        we[r]    = (state_q == BE_WRITE) && (work_i.command == CMD_UPDATE) &&
                   work_i.mask[r];
      end
    end
  end

  // Counter read for a read request; out of range reads as zero.
  always_comb begin
    read_sel = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (work_i.read_row == 2'(r)) begin
        read_sel = rdata[r];
      end
    end
    in_range = ({22'd0, work_i.read_column} < 32'(COLUMNS)) &&
               ({30'd0, work_i.read_row} < 32'(ROWS));
    result_new.counter_value = (work_i.command == CMD_READ && in_range) ? read_sel
                                                                         : '0;
    result_new.rows_updated  = (work_i.command == CMD_UPDATE) ? 4'(work_i.mask) : '0;
  end

  // One counter bank per row, registered read.
  for (genvar r = 0; r < ROWS; r++) begin : g_bank
    logic [31:0] mem [COLUMNS];
    logic [31:0] rdata_q;
    always_ff @(posedge clk_i) begin
      if (we[r]) begin
        mem[addr[r]] <= wdata[r];
      end
      rdata_q <= mem[addr[r]];
    end
    assign rdata[r] = rdata_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == BE_WRITE) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == BE_WRITE) begin
      result_q <= result_new;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = result_q;

  // A result is only loaded into a free result register.
  `SCMS_ASSERT_IMP(a_out_free, clk_i, rst_ni, state_q == BE_WRITE, !out_valid_q)
  // The request being written back is still at the head of the queue.
  `SCMS_ASSERT_IMP(a_head_held, clk_i, rst_ni, state_q == BE_WRITE, work_valid_i)
  // A result appears in the cycle after the write-back.
  `SCMS_ASSERT_NXT(a_out_load, clk_i, rst_ni, state_q == BE_WRITE, out_valid_q)

endmodule

FILE: rtl/sampled_count_min_sketch_core.sv
// Top level of the sampled count-min sketch: configuration register and wiring.
//
// Requests enter through a queue-like port: item_i is taken at a clock edge with
// push high and full low. Each request yields exactly one result, shown on
// result_o while empty is low and taken at an edge with pop high.
// An update request is hashed one key byte per cycle with CRC-32C for all
// rows at once; the front accepts it, hashes the 13 key bytes and hands it
// over, while a read request goes from acceptance straight to hand-over.
// The counter banks then do a read-modify-write in a read and a write state,
// and the next request may start only once the result register is emptied,
// so the back takes no new request before the last result has been taken.
// A two-entry queue parts front and back, and the result register parts the
// back from the receiver, so a stalled receiver holds one result while the
// front keeps hashing until that queue is full; full then stays high.
// After reset all counters are cleared in a pass over every column, one column
// of every row per cycle; full stays high throughout, while the register
// port works as ever. update_threshold sits at byte address 0.
module sampled_count_min_sketch_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  scms_pkg::scms_in_t            item_i,
  output logic                          empty,
  input  logic                          pop,
  output scms_pkg::scms_out_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scms_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import scms_pkg::*;

  logic [31:0] threshold_q;
  logic        cfg_write;
  logic        clearing;
  logic        work_valid, work_ready, wq_full, wq_empty, wq_pop;
  scms_work_t  work_in, work_out;

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1] == REG_THRESHOLD);
  assign prdata    = (paddr[PADDR_W-1] == REG_THRESHOLD) ? threshold_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold_q <= pwdata;
    end
  end

  assign work_ready = !wq_full;

  // Hashing front end.
  scms_hash_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item_i),
    .full_o       (full),
    .threshold_i  (threshold_q),
    .hold_i       (clearing),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work_in)
  );

  // Queue of classified requests.
  scms_work_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_valid),
    .data_i  (work_in),
    .full_o  (wq_full),
    .pop_i   (wq_pop),
    .data_o  (work_out),
    .empty_o (wq_empty)
  );

  // Counting back end.
  scms_count_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (!wq_empty),
    .work_i       (work_out),
    .work_pop_o   (wq_pop),
    .clearing_o   (clearing),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

endmodule

FILE: tb/sampled_count_min_sketch_core_test.sv
// Self-checking testbench for the sampled count-min sketch core.
module sampled_count_min_sketch_core_test;
  import scms_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int unsigned TIMEOUT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic [31:0] THRESHOLD_AT_RESET = 32'd171798691;
  localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F63B78;
  localparam logic [3:0][31:0] FLOW_SEEDS = {32'h00ec587f, 32'h00ec5861,
                                             32'h00ec5859, 32'h00ec5853};
  localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = PADDR_W'(4 * int'(REG_THRESHOLD));

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  scms_in_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  scms_out_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predicted sketch contents and the threshold the block should be using.
  logic [31:0] sketch_model [4][1024];
  logic [31:0] threshold_model = THRESHOLD_AT_RESET;
  scms_out_t sketch_results_due [$];
  logic [103:0] flow_keys [16];

  // Sender pacing and receiver hold orders.
  int unsigned gap_max = 6;
  int unsigned burst_left = 0;
  int unsigned hold_orders = 0;
  int unsigned hold_orders_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_percent = 0;
  int unsigned phase_left = 0;

  bit results_wrong = 1'b0;
  bit register_wrong = 1'b0;
  scms_out_t due_now;

  sampled_count_min_sketch_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Seeded CRC-32C over the 13 key bytes, first byte in the top bits.
  function automatic logic [31:0] flow_hash(input logic [103:0] key, input logic [31:0] seed);
    logic [31:0] crc;
    crc = seed;
    for (int i = 12; i >= 0; i--) begin
      crc = crc ^ {24'd0, key[i*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CASTAGNOLI_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [9:0] flow_column(input logic [103:0] key, input int row);
    logic [31:0] hash;
    hash = flow_hash(key, FLOW_SEEDS[row]);
    return hash[9:0];
  endfunction

  // Applies one accepted request to the predicted sketch and returns its result.
  function automatic scms_out_t apply_to_sketch(input scms_in_t req);
    scms_out_t res;
    logic [3:0][31:0] words;
    logic [103:0] key;
    logic [9:0] col;
    res = '0;
    if (req.command == CMD_UPDATE) begin
      key = {req.source_address, req.destination_address, req.source_port,
             req.destination_port, req.protocol};
      words = {req.random_row3, req.random_row2, req.random_row1, req.random_row0};
      for (int r = 0; r < 4; r++) begin
        if (words[r] < threshold_model) begin
          col = flow_column(key, r);
          sketch_model[r][col] = sketch_model[r][col] + 32'd1;
          res.rows_updated[r] = 1'b1;
        end
      end
    end else begin
      res.counter_value = sketch_model[req.read_row][req.read_column];
    end
    return res;
  endfunction

  function automatic logic [103:0] random_key();
    return {$urandom(), $urandom(), 16'($urandom()), 16'($urandom()), 8'($urandom())};
  endfunction

  // Sampling word biased towards the threshold and the extremes.
  function automatic logic [31:0] sampling_word(input logic [31:0] thr);
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return (thr == 32'd0) ? 32'd0 : 32'($urandom_range(thr - 32'd1, 0));
      2: return thr + 32'($urandom_range(2, 0)) - 32'd1;
      default: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // Update request; the read fields carry noise that must be ignored.
  function automatic scms_in_t make_update(input logic [103:0] key,
                                           input logic [3:0][31:0] words);
    scms_in_t req;
    req.command = CMD_UPDATE;
    {req.source_address, req.destination_address, req.source_port,
     req.destination_port, req.protocol} = key;
    {req.random_row3, req.random_row2, req.random_row1, req.random_row0} = words;
    req.read_row = 2'($urandom());
    req.read_column = 10'($urandom());
    return req;
  endfunction

  // Read request; key and sampling words carry noise that must be ignored.
  function automatic scms_in_t make_read(input logic [1:0] row, input logic [9:0] column);
    scms_in_t req;
    req.command = CMD_READ;
    {req.source_address, req.destination_address, req.source_port,
     req.destination_port, req.protocol} = random_key();
    {req.random_row3, req.random_row2, req.random_row1, req.random_row0} =
      {$urandom(), $urandom(), $urandom(), $urandom()};
    req.read_row = row;
    req.read_column = column;
    return req;
  endfunction

  // Mostly updates of a small set of recurring flows, with reads aimed at their counters.
  function automatic scms_in_t random_request();
    logic [103:0] key;
    logic [3:0][31:0] words;
    logic [1:0] row;
    if ($urandom_range(99, 0) < 75) begin
      key = ($urandom_range(9, 0) < 7) ? flow_keys[$urandom_range(15, 0)] : random_key();
      for (int r = 0; r < 4; r++) begin
        words[r] = sampling_word(threshold_model);
      end
      return make_update(key, words);
    end
    row = 2'($urandom());
    if ($urandom_range(9, 0) < 7) begin
      return make_read(row, flow_column(flow_keys[$urandom_range(15, 0)], row));
    end
    return make_read(row, 10'($urandom()));
  endfunction

  // Offers one request and records its prediction once it is taken.
  task automatic send_request(input scms_in_t req);
    push <= 1'b1;
    item_i <= req;
    do @(posedge clk_i); while (full);
    sketch_results_due.push_back(apply_to_sketch(req));
  endtask

  // Sends in bursts of random length separated by random gaps.
  task automatic send_paced(input scms_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_request(req);
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sketch_results_due.size() != 0);
  endtask

  // Optionally writes the threshold, then reads it back; only while the block is idle.
  task automatic access_threshold(input bit do_write, input logic [31:0] value);
    wait_for_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= do_write;
    paddr <= THRESHOLD_ADDR;
    pwdata <= value;
    if (do_write) begin
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      threshold_model = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== threshold_model) begin
      $display("%0t: update_threshold readback expected %h, actual %h",
               $time, threshold_model, prdata);
      register_wrong = 1'b1;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reset threshold: rows sampled just below and at the threshold, then reads.
  task automatic test_reset_state();
    logic [3:0][31:0] words;
    access_threshold(1'b0, '0);
    words = {32'hFFFF_FFFF, 32'd0, threshold_model, threshold_model - 32'd1};
    send_paced(make_update(flow_keys[2], words));
    send_paced(make_read(2'd0, flow_column(flow_keys[2], 0)));
    send_paced(make_read(2'd1, flow_column(flow_keys[2], 1)));
    send_paced(make_read(2'd0, 10'd0));
    send_paced(make_read(2'd3, 10'h3FF));
  endtask

  // All-zero and all-one keys and sampling words, repeated hits on one flow.
  task automatic test_field_extremes();
    access_threshold(1'b1, 32'hFFFF_FFFF);
    send_paced(make_update('0, '0));
    send_paced(make_update('1, {4{32'hFFFF_FFFE}}));
    send_paced(make_update('1, '1));
    repeat (3) send_paced(make_update('0, '0));
    for (int r = 0; r < 4; r++) begin
      send_paced(make_read(2'(r), flow_column('0, r)));
    end
    send_paced(make_read(2'd3, flow_column('1, 3)));
  endtask

  // Random traffic under a range of thresholds, the extremes among them.
  task automatic test_random_traffic();
    logic [31:0] settings [6];
    int unsigned counts [6];
    settings = '{32'hFFFF_FFFF, 32'h8000_0000, $urandom(), THRESHOLD_AT_RESET, 32'd1, 32'd0};
    counts = '{300, 250, 200, 200, 100, 100};
    for (int i = 0; i < 6; i++) begin
      access_threshold(1'b1, settings[i]);
      gap_max = (i == 1 || i == 4) ? 0 : 10;
      repeat (counts[i]) send_paced(random_request());
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_receiver_hold();
    access_threshold(1'b1, 32'hC000_0000);
    gap_max = 0;
    hold_orders <= hold_orders + 1;
    repeat (40) send_paced(random_request());
  endtask

  // Sender stops after each burst until every result is back.
  task automatic test_drain_pause();
    access_threshold(1'b1, 32'h4000_0000);
    gap_max = 4;
    repeat (4) begin
      repeat (10) send_paced(random_request());
      wait_for_drain();
    end
  endtask

  // Receiver: long holds on order, otherwise a stall rate that changes by phase.
  always @(posedge clk_i) begin
    if (hold_orders != hold_orders_seen) begin
      hold_orders_seen <= hold_orders;
      hold_left <= LONG_HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(3, 0))
          0: stall_percent <= 0;
          1: stall_percent <= 20;
          2: stall_percent <= 50;
          default: stall_percent <= 80;
        endcase
        phase_left <= $urandom_range(200, 50);
      end else begin
        phase_left <= phase_left - 1;
      end
      pop <= ($urandom_range(99, 0) >= stall_percent);
    end
  end

  // Each result taken is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (sketch_results_due.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, result_o);
        results_wrong = 1'b1;
      end else begin
        due_now = sketch_results_due.pop_front();
        if (result_o.counter_value !== due_now.counter_value) begin
          $display("%0t: counter_value expected %h, actual %h",
                   $time, due_now.counter_value, result_o.counter_value);
          results_wrong = 1'b1;
        end
        if (result_o.rows_updated !== due_now.rows_updated) begin
          $display("%0t: rows_updated expected %h, actual %h",
                   $time, due_now.rows_updated, result_o.rows_updated);
          results_wrong = 1'b1;
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 1024; c++) begin
        sketch_model[r][c] = 32'd0;
      end
    end
    flow_keys[0] = '0;
    flow_keys[1] = '1;
    for (int i = 2; i < 16; i++) begin
      flow_keys[i] = random_key();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_field_extremes();
    test_random_traffic();
    test_receiver_hold();
    test_drain_pause();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!results_wrong && !register_wrong && sketch_results_due.size() == 0) begin
      $display("sampled_count_min_sketch_core test passed");
    end else begin
      $display("sampled_count_min_sketch_core test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("sampled_count_min_sketch_core test failed");
    $finish;
  end

endmodule
